// File: sv/pfr_pkg.sv
// Package for the page frame replacement block.
// Item types, register indexes, state codes and reset constants; no dependencies.
`default_nettype none
package pfr_pkg;

  localparam int unsigned DefNumFrames = 16;
  localparam int unsigned DefNumPages  = 256;
  localparam int unsigned DefStampBits = 32;

  localparam int unsigned AddrW   = 31;
  localparam int unsigned PsizeW  = 17;
  localparam int unsigned FrCfgW  = 5;
  localparam int unsigned PgCfgW  = 9;
  localparam int unsigned CntW    = 32;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [PsizeW-1:0] PsizeRst = 17'd4096;
  localparam logic [FrCfgW-1:0] FrRst    = 5'd16;
  localparam logic [PgCfgW-1:0] PgRst    = 9'd256;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAGE_SIZE = 8'd0,
    REG_USE_LRU   = 8'd1,
    REG_FRAMES    = 8'd2,
    REG_PAGES     = 8'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_CHECK, ST_SCAN, ST_UPDATE, ST_DONE
  } state_e;

  typedef struct packed {
    logic             opcode;
    logic [AddrW-1:0] address;
  } cmd_t;

  typedef struct packed {
    logic [30:0]     page_index;
    logic            hit;
    logic [3:0]      frame_index;
    logic            victim_valid;
    logic [7:0]      victim_page;
    logic            victim_written_back;
    logic            recovered_from_swap;
    logic            range_error;
    logic [CntW-1:0] miss_total;
    logic [CntW-1:0] stolen_total;
    logic [CntW-1:0] writeback_total;
    logic [CntW-1:0] recovery_total;
  } rsp_t;

endpackage
`default_nettype wire

// File: sv/page_frame_replacement.sv
// Top level of the page frame replacement block (FIFO/LRU demand paging).
// Depends on pfr_pkg.
//
// channel  signals                          direction
// in       in_valid_i in_ready_o in_data_i  item in (opcode, address)
// out      out_valid_o out_ready_i out_data_o  result item out
// cfg      cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i  register write
//
// An item passes through a one-bit-per-cycle restoring divider for the page number,
// then one frame per cycle through a single stamp comparator. A range error skips
// the frame scan.
// Reset clears the frame table, swap marks and counts at once; no clearing pass.
// A finished result waits in the output register while the next item is accepted.
`default_nettype none
module page_frame_replacement #(
  parameter int unsigned FRAME_COUNT = pfr_pkg::DefNumFrames,
  parameter int unsigned PAGE_COUNT  = pfr_pkg::DefNumPages,
  parameter int unsigned STAMP_BITS  = pfr_pkg::DefStampBits
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  pfr_pkg::cmd_t                in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output pfr_pkg::rsp_t                out_data_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [pfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [pfr_pkg::PsizeW-1:0]    cfg_data_i
);
  import pfr_pkg::*;

  localparam int unsigned FrameW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned PageW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam logic [FrameW-1:0] LastFrame = FrameW'(FRAME_COUNT - 1);
  localparam logic [CntW-1:0] CntMax = '1;

  state_e state_q, state_d;

  logic [PsizeW-1:0] psize_q;
  logic              lru_q;
  logic [FrCfgW-1:0] frames_q;
  logic [PgCfgW-1:0] pages_q;

  logic              wr_q;
  logic [AddrW-1:0]  addr_q;
  logic [AddrW-1:0]  quot_q;
  logic [PsizeW:0]   rem_q;
  logic [4:0]        bit_q;

  logic [PageW-1:0]      frame_page_q [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] used_q, dirty_q;
  logic [STAMP_BITS-1:0] first_q [FRAME_COUNT];
  logic [STAMP_BITS-1:0] last_q  [FRAME_COUNT];
  logic [PAGE_COUNT-1:0] on_disk_q;
  logic                  disk_q;
  logic [STAMP_BITS-1:0] now_q;
  logic [CntW-1:0] miss_q, stolen_q, wb_q, recov_q;

  logic [FrameW-1:0]     idx_q, hit_f_q, free_f_q, vic_q;
  logic                  hit_q, free_q;
  logic [STAMP_BITS-1:0] best_q;
  rsp_t                  res_q;
  logic                  out_valid_q;
  rsp_t                  out_q;

  logic [PsizeW-1:0] psize;
  logic [8:0]        nframes;
  logic [PgCfgW-1:0] npages;
  logic [PsizeW:0]   rem_sh;
  logic              rem_ge;
  logic              range_err;
  logic [PageW-1:0]  page;
  logic              in_act;
  logic [STAMP_BITS-1:0] cand;
  logic              take;
  logic              done_load;

  always_comb begin
    psize = (psize_q == '0) ? PsizeW'(1) : psize_q;
    if (frames_q == '0) begin
      nframes = 9'd1;
    end else if (32'(frames_q) > FRAME_COUNT) begin
      nframes = 9'(FRAME_COUNT);
    end else begin
      nframes = 9'(frames_q);
    end
    npages = (32'(pages_q) > PAGE_COUNT) ? PgCfgW'(PAGE_COUNT) : pages_q;
    rem_sh = {rem_q[PsizeW-1:0], addr_q[bit_q]};
    rem_ge = rem_sh >= {1'b0, psize};
    range_err = quot_q >= AddrW'(npages);
    page = quot_q[PageW-1:0];
    in_act = 9'(idx_q) < nframes;
    cand = lru_q ? last_q[idx_q] : first_q[idx_q];
    take = (idx_q == '0) || (cand < best_q);
    done_load = !out_valid_q || out_ready_i;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DIV;
      ST_DIV:    if (bit_q == '0) state_d = ST_CHECK;
      ST_CHECK:  state_d = range_err ? ST_DONE : ST_SCAN;
      ST_SCAN:   if (idx_q == LastFrame) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DONE;
      ST_DONE:   if (done_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cfg_ready_o = 1'b1;
    out_valid_o = out_valid_q;
    out_data_o  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      psize_q     <= PsizeRst;
      lru_q       <= 1'b0;
      frames_q    <= FrRst;
      pages_q     <= PgRst;
      used_q      <= '0;
      dirty_q     <= '0;
      on_disk_q   <= '0;
      now_q       <= '0;
      miss_q      <= '0;
      stolen_q    <= '0;
      wb_q        <= '0;
      recov_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
        first_q[i] <= '1;
        last_q[i]  <= '1;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PAGE_SIZE: psize_q  <= cfg_data_i;
          REG_USE_LRU:   lru_q    <= cfg_data_i[0];
          REG_FRAMES:    frames_q <= cfg_data_i[FrCfgW-1:0];
          REG_PAGES:     pages_q  <= cfg_data_i[PgCfgW-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_DONE && done_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CHECK: if (!range_err) now_q <= now_q + 1'b1;
        ST_UPDATE: begin
          if (hit_q) begin
            last_q[hit_f_q] <= now_q;
            if (wr_q) dirty_q[hit_f_q] <= 1'b1;
          end else begin
            if (miss_q != CntMax) miss_q <= miss_q + 1'b1;
            first_q[free_q ? free_f_q : vic_q] <= now_q;
            last_q[free_q ? free_f_q : vic_q]  <= now_q;
            dirty_q[free_q ? free_f_q : vic_q] <= wr_q;
            if (free_q) begin
              used_q[free_f_q] <= 1'b1;
              on_disk_q[page]  <= 1'b0;
            end else begin
              if (stolen_q != CntMax) stolen_q <= stolen_q + 1'b1;
              if (dirty_q[vic_q]) begin
                on_disk_q[frame_page_q[vic_q]] <= 1'b1;
                if (wb_q != CntMax) wb_q <= wb_q + 1'b1;
              end
              if (disk_q && recov_q != CntMax) recov_q <= recov_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        wr_q   <= in_data_i.opcode;
        addr_q <= in_data_i.address;
        rem_q  <= '0;
        bit_q  <= 5'(AddrW - 1);
      end
      ST_DIV: begin
        rem_q  <= rem_ge ? rem_sh - {1'b0, psize} : rem_sh;
        quot_q <= {quot_q[AddrW-2:0], rem_ge};
        bit_q  <= bit_q - 1'b1;
      end
      ST_CHECK: begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        disk_q <= on_disk_q[page];
        res_q  <= '{page_index: quot_q, range_error: range_err, miss_total: miss_q,
                   stolen_total: stolen_q, writeback_total: wb_q,
                   recovery_total: recov_q, default: '0};
      end
      ST_SCAN: begin
        idx_q <= idx_q + 1'b1;
        if (!hit_q && used_q[idx_q] && frame_page_q[idx_q] == page) begin
          hit_q   <= 1'b1;
          hit_f_q <= idx_q;
        end
        if (!free_q && in_act && !used_q[idx_q]) begin
          free_q   <= 1'b1;
          free_f_q <= idx_q;
        end
        if (in_act && take) begin
          best_q <= cand;
          vic_q  <= idx_q;
        end
      end
      ST_UPDATE: begin
        res_q.hit <= hit_q;
        if (hit_q) begin
          res_q.frame_index <= 4'(hit_f_q);
        end else begin
          res_q.miss_total <= (miss_q != CntMax) ? miss_q + 1'b1 : miss_q;
          res_q.frame_index <= 4'(free_q ? free_f_q : vic_q);
          frame_page_q[free_q ? free_f_q : vic_q] <= page;
          if (!free_q) begin
            res_q.victim_valid        <= 1'b1;
            res_q.victim_page         <= 8'(frame_page_q[vic_q]);
            res_q.victim_written_back <= dirty_q[vic_q];
            res_q.recovered_from_swap <= disk_q;
            res_q.stolen_total <= (stolen_q != CntMax) ? stolen_q + 1'b1 : stolen_q;
            if (dirty_q[vic_q]) begin
              res_q.writeback_total <= (wb_q != CntMax) ? wb_q + 1'b1 : wb_q;
            end
            if (disk_q) begin
              res_q.recovery_total <= (recov_q != CntMax) ? recov_q + 1'b1 : recov_q;
            end
          end
        end
      end
      ST_DONE: if (done_load) out_q <= res_q;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside done state");
  a_hit_no_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.hit && out_q.victim_valid))
    else $error("hit with victim");
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.range_error |-> !out_q.hit && !out_q.victim_valid)
    else $error("range error with frame result");
  a_wb_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.victim_written_back |-> out_q.victim_valid)
    else $error("write back without victim");
`endif

endmodule
`default_nettype wire
